// ===== src/sign_magnitude_restoring_divider_defines.svh =====
// assertion macros shared by the divider checker
`ifndef SIGN_MAGNITUDE_RESTORING_DIVIDER_DEFINES_SVH
`define SIGN_MAGNITUDE_RESTORING_DIVIDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("divider check failed");

// next-cycle implication, sampled on clk, off during reset
`define SMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("divider check failed");

`endif

// ===== src/smdiv_pkg.sv =====
// shared constants, types and field layout of the sign-magnitude divider
`default_nettype none

package smdiv_pkg;

  // magnitude and field widths
  localparam int MAG_W = 96;
  localparam int LO_W  = 64;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int CNT_W = $clog2(MAG_W);

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS     = 2 * MAG_W + 2;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * MAG_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } smdiv_state_t;

  // strobes from sequencer to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } smdiv_ctl_t;

endpackage

`default_nettype wire

// ===== src/smdiv_datapath.sv =====
// shift-register datapath: one restoring quotient bit per step
`default_nettype none

module smdiv_datapath
  import smdiv_pkg::*;
(
  input  wire logic             clk,
  input  wire smdiv_ctl_t       ctl,
  input  wire logic [MAG_W-1:0] dividend,
  input  wire logic             dividend_negative,
  input  wire logic [MAG_W-1:0] divisor,
  input  wire logic             divisor_negative,
  output logic      [MAG_W-1:0] quotient,
  output logic                  quotient_negative,
  output logic      [MAG_W-1:0] remainder,
  output logic                  divide_by_zero
);

  logic [MAG_W-1:0] a_r, a_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] div_r;
  logic             sign_r;
  logic             dbz_r;
  logic [MAG_W-1:0] q_out_r;
  logic [MAG_W-1:0] r_out_r;
  logic             s_out_r;
  logic             z_out_r;

  logic [MAG_W:0]   shifted;
  logic [MAG_W+1:0] diff;
  logic             q_bit;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_r, a_r[MAG_W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_r};
    q_bit   = ~diff[MAG_W+1];
    rem_nxt = q_bit ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
    a_nxt   = {a_r[MAG_W-2:0], q_bit};
  end

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r    <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
      sign_r <= dividend_negative ^ divisor_negative;
      dbz_r  <= (divisor == '0);
    end else if (ctl.step) begin
      a_r   <= a_nxt;
      rem_r <= rem_nxt;
    end
  end

  // output register, zeroed on divide by zero
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      q_out_r <= dbz_r ? '0 : a_r;
      r_out_r <= dbz_r ? '0 : rem_r;
      s_out_r <= dbz_r ? 1'b0 : sign_r;
      z_out_r <= dbz_r;
    end
  end

  assign quotient          = q_out_r;
  assign remainder         = r_out_r;
  assign quotient_negative = s_out_r;
  assign divide_by_zero    = z_out_r;

endmodule

`default_nettype wire

// ===== src/smdiv_ctrl.sv =====
// sequencer: step counter, handshakes and output valid
`default_nettype none

module smdiv_ctrl
  import smdiv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output smdiv_ctl_t ctl
);

  smdiv_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovld_r, ovld_nxt;
  logic             last_step;

  assign last_step = (cnt_r == CNT_W'(MAG_W - 1));

  // state, counter and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r;
    ctl       = '0;
    in_ready  = 1'b0;
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        // no transaction is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (last_step) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (!ovld_r || out_ready) begin
          ctl.emit  = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = ovld_r;

endmodule

`default_nettype wire

// ===== src/sign_magnitude_restoring_divider.sv =====
// sequence: load the transaction, 96 restoring steps, load the output register, result valid
// the single shared 97-bit subtractor produces one quotient bit per cycle; a new transaction
// is taken only in idle, and a waiting result does not block that accept
// reset: synchronous active-low rst_n clears the sequencer and the output valid
// top level of the sign-magnitude restoring divider
`default_nettype none

module sign_magnitude_restoring_divider
  import smdiv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // dividend_low, dividend_high, dividend_negative, divisor_low, divisor_high,
  // divisor_negative, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // quotient_low, quotient_high, quotient_negative, remainder_low, remainder_high, zero pad
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // divide_by_zero
  output logic      [0:0]             out_tuser
);

  smdiv_ctl_t       ctl;
  logic [MAG_W-1:0] quotient;
  logic [MAG_W-1:0] remainder;
  logic             quotient_negative;
  logic             divide_by_zero;

  smdiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ctl       (ctl)
  );

  smdiv_datapath u_dp (
    .clk               (clk),
    .ctl               (ctl),
    .dividend          (in_tdata[MAG_W-1:0]),
    .dividend_negative (in_tdata[MAG_W]),
    .divisor           (in_tdata[2*MAG_W:MAG_W+1]),
    .divisor_negative  (in_tdata[2*MAG_W+1]),
    .quotient          (quotient),
    .quotient_negative (quotient_negative),
    .remainder         (remainder),
    .divide_by_zero    (divide_by_zero)
  );

  // result packing
  assign out_tdata = {{OUT_PAD_W{1'b0}}, remainder, quotient_negative, quotient};
  assign out_tuser = divide_by_zero;

endmodule

`default_nettype wire

// ===== src/smdiv_checker.sv =====
// port-level checker for the divider, bound to the top level
`default_nettype none
`include "sign_magnitude_restoring_divider_defines.svh"

module smdiv_checker
  import smdiv_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [0:0]             out_tuser
);

  // a stalled result holds
  `SMD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // divide by zero returns all-zero quotient, sign and remainder
  `SMD_ASSERT_IMP(a_dbz_zero, out_tvalid && out_tuser[0], out_tdata == '0)
  // the divider is busy right after taking a transaction
  `SMD_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready)
  // padding bits stay zero
  `SMD_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[OUT_TDATA_W-1:OUT_BITS] == '0)

endmodule

bind sign_magnitude_restoring_divider smdiv_checker u_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for the sign-magnitude restoring divider
module tb;
  import smdiv_pkg::*;

  localparam int PERIOD     = 12;
  localparam int RAND_ITEMS = 2000;
  localparam int LONG_HOLD  = 600;
  localparam int HOLD_AT    = 300;
  localparam int DRAIN_WAIT = 250;
  localparam int LIMIT_CYC  = 1_200_000;

  // input transaction layout, first field in the lowest bits
  typedef struct packed {
    logic [IN_TDATA_W-IN_BITS-1:0] pad;
    logic                          divisor_negative;
    logic [HI_W-1:0]               divisor_high;
    logic [LO_W-1:0]               divisor_low;
    logic                          dividend_negative;
    logic [HI_W-1:0]               dividend_high;
    logic [LO_W-1:0]               dividend_low;
  } div_req_t;

  // result transaction layout, divide by zero travels on tuser
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [HI_W-1:0]      remainder_high;
    logic [LO_W-1:0]      remainder_low;
    logic                 quotient_negative;
    logic [HI_W-1:0]      quotient_high;
    logic [LO_W-1:0]      quotient_low;
  } div_word_t;

  typedef struct packed {
    logic [LO_W-1:0] quotient_low;
    logic [HI_W-1:0] quotient_high;
    logic            quotient_negative;
    logic [LO_W-1:0] remainder_low;
    logic [HI_W-1:0] remainder_high;
    logic            divide_by_zero;
  } quot_rem_t;

  typedef struct packed {
    div_req_t  req;
    logic      typed_in;
    quot_rem_t want;
  } div_case_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  quot_rem_t   expected_quotients[$];
  div_case_t   directed_cases[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned divisions_accepted = 0;

  sign_magnitude_restoring_divider u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(PERIOD / 2) clk = ~clk;

  // operand packing
  function automatic div_req_t mk_req(logic [MAG_W-1:0] num, logic num_neg,
                                      logic [MAG_W-1:0] den, logic den_neg);
    div_req_t req;
    req = '0;
    {req.dividend_high, req.dividend_low} = num;
    req.dividend_negative = num_neg;
    {req.divisor_high, req.divisor_low} = den;
    req.divisor_negative = den_neg;
    return req;
  endfunction

  function automatic quot_rem_t mk_res(logic [MAG_W-1:0] q, logic q_neg,
                                       logic [MAG_W-1:0] r, logic dbz);
    quot_rem_t res;
    {res.quotient_high, res.quotient_low} = q;
    res.quotient_negative = q_neg;
    {res.remainder_high, res.remainder_low} = r;
    res.divide_by_zero = dbz;
    return res;
  endfunction

  // expected quotient, remainder and sign of one division
  function automatic quot_rem_t divide_sign_mag(div_req_t req);
    logic [MAG_W-1:0] num, den;
    num = {req.dividend_high, req.dividend_low};
    den = {req.divisor_high, req.divisor_low};
    if (den == '0) return mk_res('0, 1'b0, '0, 1'b1);
    return mk_res(num / den, req.dividend_negative ^ req.divisor_negative,
                  num % den, 1'b0);
  endfunction

  // random magnitude of at most nbits significant bits
  function automatic logic [MAG_W-1:0] rand_mag(int unsigned nbits);
    logic [MAG_W-1:0] full;
    full = {$urandom, $urandom, $urandom};
    if (nbits == 0) return '0;
    return full >> (MAG_W - nbits);
  endfunction

  function automatic div_req_t rand_req();
    int unsigned kind, nb;
    logic [MAG_W-1:0] num, den;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      num = rand_mag($urandom_range(0, MAG_W));
      den = '0;
    end else if (kind < 15) begin
      num = rand_mag($urandom_range(0, MAG_W));
      den = rand_mag($urandom_range(1, MAG_W));
    end else if (kind < 25) begin
      num = rand_mag(MAG_W);
      den = rand_mag(MAG_W);
    end else begin
      nb  = $urandom_range(1, MAG_W);
      num = rand_mag(nb);
      den = rand_mag($urandom_range(1, nb));
    end
    return mk_req(num, 1'($urandom_range(0, 1)), den, 1'($urandom_range(0, 1)));
  endfunction

  task automatic add_case(div_req_t req, logic typed_in, quot_rem_t want);
    div_case_t c;
    c.req = req;
    c.typed_in = typed_in;
    c.want = want;
    directed_cases.push_back(c);
  endtask

  task automatic note_mismatch(string what);
    $display("tb: mismatch at result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [LO_W-1:0] got, logic [LO_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // offer one division and wait for its transaction
  task automatic send_division(div_req_t req, quot_rem_t want);
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_quotients.push_back(want);
    divisions_accepted++;
  endtask

  // result checking
  always @(posedge clk) begin
    div_word_t got;
    quot_rem_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_quotients.size() == 0) begin
        note_mismatch("result with no division pending");
      end else begin
        want = expected_quotients.pop_front();
        check_field("quotient_low", got.quotient_low, want.quotient_low);
        check_field("quotient_high", LO_W'(got.quotient_high), LO_W'(want.quotient_high));
        check_field("quotient_negative", LO_W'(got.quotient_negative),
                    LO_W'(want.quotient_negative));
        check_field("remainder_low", got.remainder_low, want.remainder_low);
        check_field("remainder_high", LO_W'(got.remainder_high),
                    LO_W'(want.remainder_high));
        check_field("divide_by_zero", LO_W'(out_tuser[0]), LO_W'(want.divide_by_zero));
      end
      results_seen++;
    end
  end

  // receiver backpressure: rotating stall patterns plus one long hold-off
  initial begin : rx_ready
    int unsigned cyc;
    bit held;
    cyc  = 0;
    held = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && divisions_accepted >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      case ((cyc / 200) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= (cyc % 3) != 0;
        2: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= (cyc % 16) >= 10;
      endcase
      cyc++;
      @(posedge clk);
    end
  end

  // reset, stimulus and end of run
  initial begin : stim
    int unsigned burst_left, gap;
    logic [MAG_W-1:0] all1, top;
    all1 = '1;
    top  = {1'b1, {(MAG_W-1){1'b0}}};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;

    // zero divisor, extremes, sign handling, short dividends
    add_case(mk_req('0, 1'b0, '0, 1'b0), 1'b1, mk_res('0, 1'b0, '0, 1'b1));
    add_case(mk_req(all1, 1'b1, '0, 1'b0), 1'b1, mk_res('0, 1'b0, '0, 1'b1));
    add_case(mk_req('0, 1'b1, MAG_W'(5), 1'b0), 1'b1, mk_res('0, 1'b1, '0, 1'b0));
    add_case(mk_req(all1, 1'b0, MAG_W'(1), 1'b1), 1'b1, mk_res(all1, 1'b1, '0, 1'b0));
    add_case(mk_req(all1, 1'b1, all1, 1'b1), 1'b1, mk_res(MAG_W'(1), 1'b0, '0, 1'b0));
    add_case(mk_req(MAG_W'(1), 1'b0, all1, 1'b0), 1'b1,
             mk_res('0, 1'b0, MAG_W'(1), 1'b0));
    add_case(mk_req(all1, 1'b0, MAG_W'(2), 1'b0), 1'b1,
             mk_res(all1 >> 1, 1'b0, MAG_W'(1), 1'b0));
    add_case(mk_req(top, 1'b1, top, 1'b0), 1'b1, mk_res(MAG_W'(1), 1'b1, '0, 1'b0));
    add_case(mk_req(MAG_W'(100), 1'b1, MAG_W'(7), 1'b1), 1'b1,
             mk_res(MAG_W'(14), 1'b0, MAG_W'(2), 1'b0));
    add_case(mk_req(all1 - MAG_W'(1), 1'b0, all1, 1'b1), 1'b1,
             mk_res('0, 1'b1, all1 - MAG_W'(1), 1'b0));
    add_case(mk_req(top, 1'b0, MAG_W'(3), 1'b0), 1'b0, '0);
    add_case(mk_req({32'hFFFF_FFFF, 64'h0}, 1'b0, {32'h1, 64'h0}, 1'b0), 1'b0, '0);
    add_case(mk_req({32'h1, 64'h0}, 1'b0, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0),
             1'b0, '0);
    add_case(mk_req({3{32'hAAAA_AAAA}}, 1'b0, {3{32'h5555_5555}}, 1'b1), 1'b0, '0);
    add_case(mk_req({3{32'h5555_5555}}, 1'b1, {3{32'hAAAA_AAAA}}, 1'b0), 1'b0, '0);
    add_case(mk_req(all1, 1'b0, {32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0), 1'b0, '0);
    add_case(mk_req(all1, 1'b1, {32'h8000_0000, 64'h0}, 1'b1), 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < directed_cases.size() + RAND_ITEMS; i++) begin
      div_req_t  req;
      quot_rem_t want;
      if (i < directed_cases.size()) begin
        req  = directed_cases[i].req;
        want = directed_cases[i].typed_in ? directed_cases[i].want : divide_sign_mag(req);
      end else begin
        req  = rand_req();
        want = divide_sign_mag(req);
      end
      send_division(req, want);

      // sender bursts with idle gaps in between
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
    end
    in_tvalid <= 1'b0;

    // drain pending results, then watch for strays
    while (expected_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #(PERIOD * LIMIT_CYC);
    $display("tb: failure");
    $finish;
  end

endmodule
